[rtl/esbd_pkg.sv]
// ----------------------------------------------------------------------------
// esbd_pkg: shared types and constants for the epoch-to-datetime converter
// Holds the reciprocal constants, the cumulative month table, the payload
// structs passed between pipeline segments and the small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package esbd_pkg;

  // Exact divide by 60 for any 32-bit value: q = (x * RECIP60) >> SHIFT60
  localparam logic [31:0] RECIP60 = 32'h8888_8889;
  localparam int          SHIFT60 = 37;

  // Exact divide by 24 for values below 2**15: q = (x * RECIP24) >> SHIFT24
  localparam logic [14:0] RECIP24 = 15'd21846;
  localparam int          SHIFT24 = 19;

  // Hours in one four-year cycle (1461 days)
  localparam logic [15:0] HOURS_PER_CYCLE = 16'd35064;

  // Hour offsets of the second, third and fourth year of a cycle.
  // A cycle starts at a year with (year mod 4) == 2, so the third year is the leap one.
  localparam logic [15:0] YEAR1_START = 16'd8760;
  localparam logic [15:0] YEAR2_START = 16'd17520;
  localparam logic [15:0] YEAR3_START = 16'd26304;
  localparam logic [1:0]  LEAP_YEAR_OFS = 2'd2;

  localparam logic [11:0] FIRST_YEAR   = 12'd1970;
  localparam logic [11:0] CENTURY_BASE = 12'd1900;

  // Last day of year (1-based, common year) of January through November
  localparam logic [8:0] CUM_END [11] = '{
    9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam logic [8:0] FEB29_DOY = 9'd60;

  typedef struct packed {
    logic [20:0] hours;
    logic [5:0]  minute;
    logic [5:0]  second;
  } esbd_hms_t;

  typedef struct packed {
    logic [11:0] year;
    logic        leap;
    logic [13:0] hrem;
    logic [5:0]  minute;
    logic [5:0]  second;
  } esbd_yr_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } esbd_date_t;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
  } esbd_md_t;

  // Month and day from zero-based day of year
  function automatic esbd_md_t month_day(input logic [8:0] doy0, input logic leap);
    logic [8:0] t;
    logic [8:0] start;
    logic [3:0] mon;
    esbd_md_t   res;
    t     = doy0 + 9'd1;
    start = 9'd0;
    mon   = 4'd0;
    if (leap && (t > FEB29_DOY)) begin
      t = t - 9'd1;
    end
    for (int i = 0; i < 11; i++) begin
      if (CUM_END[i] < t) begin
        mon   = 4'(i + 1);
        start = CUM_END[i];
      end
    end
    res.month = mon + 4'd1;
    res.day   = 5'(t - start);
    if (leap && (doy0 + 9'd1 == FEB29_DOY)) begin
      res.month = 4'd2;
      res.day   = 5'd29;
    end
    return res;
  endfunction

  // Packed BCD of a value below 100; tens via x*205 >> 11
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

`default_nettype wire

[rtl/esbd_hms.sv]
// ----------------------------------------------------------------------------
// esbd_hms: seconds and minutes split
// Four stages: two reciprocal multiplies by 1/60, each followed by a stage
// that forms the quotient and the remainder. Hands on the hour count.
// ----------------------------------------------------------------------------
`default_nettype none

module esbd_hms
  import esbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output esbd_hms_t        out_data
);

  logic [3:0] vld;
  logic [3:0] adv;

  // stage 1
  logic [31:0] s1_t;
  logic [63:0] s1_prod;
  // stage 2
  logic [26:0] s2_q;
  logic [5:0]  s2_sec;
  // stage 3
  logic [26:0] s3_q;
  logic [5:0]  s3_sec;
  logic [63:0] s3_prod;
  // stage 4
  logic [20:0] s4_hours;
  logic [5:0]  s4_min;
  logic [5:0]  s4_sec;

  logic [26:0] q1;
  logic [31:0] q1x60;
  logic [20:0] hrs;
  logic [26:0] hx60;

  assign adv[3]   = !vld[3] || out_ready;
  assign adv[2]   = !vld[2] || adv[3];
  assign adv[1]   = !vld[1] || adv[2];
  assign adv[0]   = !vld[0] || adv[1];
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
    end
  end

  assign q1    = s1_prod[63:SHIFT60];
  assign q1x60 = ({5'b0, q1} << 6) - ({5'b0, q1} << 2);
  assign hrs   = s3_prod[SHIFT60+20:SHIFT60];
  assign hx60  = ({6'b0, hrs} << 6) - ({6'b0, hrs} << 2);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_t    <= epoch_seconds;
      s1_prod <= {32'b0, epoch_seconds} * {32'b0, RECIP60};
    end
    if (adv[1]) begin
      s2_q   <= q1;
      s2_sec <= 6'(s1_t - q1x60);
    end
    if (adv[2]) begin
      s3_q    <= s2_q;
      s3_sec  <= s2_sec;
      s3_prod <= {37'b0, s2_q} * {32'b0, RECIP60};
    end
    if (adv[3]) begin
      s4_hours <= hrs;
      s4_min   <= 6'(s3_q - hx60);
      s4_sec   <= s3_sec;
    end
  end

  assign out_valid       = vld[3];
  assign out_data.hours  = s4_hours;
  assign out_data.minute = s4_min;
  assign out_data.second = s4_sec;

endmodule

`default_nettype wire

[rtl/esbd_year.sv]
// ----------------------------------------------------------------------------
// esbd_year: four-year cycle and year within the cycle
// Restoring division of the hour count by the cycle length, three quotient
// bits per stage, then a compare stage that picks the year in the cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module esbd_year
  import esbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire esbd_hms_t  in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output esbd_yr_t        out_data
);

  logic [2:0] vld;
  logic [2:0] adv;

  logic [20:0] s1_rem;
  logic [2:0]  s1_qhi;
  logic [5:0]  s1_min;
  logic [5:0]  s1_sec;

  logic [15:0] s2_rem;
  logic [5:0]  s2_q;
  logic [5:0]  s2_min;
  logic [5:0]  s2_sec;

  esbd_yr_t    s3;

  logic [20:0] r_hi;
  logic [2:0]  q_hi;
  logic [20:0] r_lo;
  logic [2:0]  q_lo;
  logic [1:0]  yofs;
  logic [15:0] ybase;

  assign adv[2]   = !vld[2] || out_ready;
  assign adv[1]   = !vld[1] || adv[2];
  assign adv[0]   = !vld[0] || adv[1];
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
    end
  end

  // quotient bits 5..3
  always_comb begin
    r_hi = in_data.hours;
    q_hi = '0;
    for (int k = 2; k >= 0; k--) begin
      if (r_hi >= (21'(HOURS_PER_CYCLE) << (k + 3))) begin
        r_hi    = r_hi - (21'(HOURS_PER_CYCLE) << (k + 3));
        q_hi[k] = 1'b1;
      end
    end
  end

  // quotient bits 2..0
  always_comb begin
    r_lo = s1_rem;
    q_lo = '0;
    for (int k = 2; k >= 0; k--) begin
      if (r_lo >= (21'(HOURS_PER_CYCLE) << k)) begin
        r_lo    = r_lo - (21'(HOURS_PER_CYCLE) << k);
        q_lo[k] = 1'b1;
      end
    end
  end

  // year within the cycle
  always_comb begin
    priority if (s2_rem < YEAR1_START) begin
      yofs  = 2'd0;
      ybase = 16'd0;
    end else if (s2_rem < YEAR2_START) begin
      yofs  = 2'd1;
      ybase = YEAR1_START;
    end else if (s2_rem < YEAR3_START) begin
      yofs  = 2'd2;
      ybase = YEAR2_START;
    end else begin
      yofs  = 2'd3;
      ybase = YEAR3_START;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_rem <= r_hi;
      s1_qhi <= q_hi;
      s1_min <= in_data.minute;
      s1_sec <= in_data.second;
    end
    if (adv[1]) begin
      s2_rem <= r_lo[15:0];
      s2_q   <= {s1_qhi, q_lo};
      s2_min <= s1_min;
      s2_sec <= s1_sec;
    end
    if (adv[2]) begin
      s3.year   <= FIRST_YEAR + {4'b0, s2_q, yofs};
      s3.leap   <= (yofs == LEAP_YEAR_OFS);
      s3.hrem   <= 14'(s2_rem - ybase);
      s3.minute <= s2_min;
      s3.second <= s2_sec;
    end
  end

  assign out_valid = vld[2];
  assign out_data  = s3;

endmodule

`default_nettype wire

[rtl/esbd_date.sv]
// ----------------------------------------------------------------------------
// esbd_date: hour of day, month and day
// Multiply by 1/24, split hour and day of year, then walk the month table.
// ----------------------------------------------------------------------------
`default_nettype none

module esbd_date
  import esbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire esbd_yr_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output esbd_date_t      out_data
);

  logic [2:0] vld;
  logic [2:0] adv;

  esbd_yr_t    s1;
  logic [28:0] s1_prod;

  logic [11:0] s2_year;
  logic        s2_leap;
  logic [8:0]  s2_doy;
  logic [4:0]  s2_hour;
  logic [5:0]  s2_min;
  logic [5:0]  s2_sec;

  esbd_date_t  s3;

  logic [8:0]  doy;
  logic [13:0] doyx24;
  esbd_md_t    md;

  assign adv[2]   = !vld[2] || out_ready;
  assign adv[1]   = !vld[1] || adv[2];
  assign adv[0]   = !vld[0] || adv[1];
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
    end
  end

  assign doy    = s1_prod[SHIFT24+8:SHIFT24];
  assign doyx24 = ({5'b0, doy} << 4) + ({5'b0, doy} << 3);
  assign md     = month_day(s2_doy, s2_leap);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1      <= in_data;
      s1_prod <= {15'b0, in_data.hrem} * {14'b0, RECIP24};
    end
    if (adv[1]) begin
      s2_year <= s1.year;
      s2_leap <= s1.leap;
      s2_doy  <= doy;
      s2_hour <= 5'(s1.hrem - doyx24);
      s2_min  <= s1.minute;
      s2_sec  <= s1.second;
    end
    if (adv[2]) begin
      s3.year   <= s2_year;
      s3.month  <= md.month;
      s3.day    <= md.day;
      s3.hour   <= s2_hour;
      s3.minute <= s2_min;
      s3.second <= s2_sec;
    end
  end

  assign out_valid = vld[2];
  assign out_data  = s3;

endmodule

`default_nettype wire

[rtl/epoch_seconds_to_bcd_datetime_top.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_bcd_datetime_top: epoch seconds to calendar date and time
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into year,
// month, day, hour, minute and second, in binary and in packed BCD.
//
// Usage:
//   Input channel: in_valid / in_ready carry one word, epoch_seconds.
//   Output channel: out_valid / out_ready carry one word with all twelve
//   date and time fields. A word moves when valid and ready are both high.
//   Every input word yields exactly one output word, in order.
//   Throughput: one word per cycle while out_ready is high; each of the 11
//   register stages holds its own word, and the two multiplies by 1/60, the
//   cycle division (three quotient bits per stage) and the multiply by 1/24
//   each have stages of their own.
//   Reset (rst, synchronous, active high) drops every word in flight; the
//   block holds no other state.
//   Stall: when out_ready is low, the output register holds its word and
//   stages fill up behind it; in_ready stays high while any stage is empty,
//   so bubbles close up and no word is lost or repeated.
//   The year runs on a plain every-fourth-year leap rule, so 2100-02-29
//   exists; bcd_year keeps only the last two digits.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_bcd_datetime_top
  import esbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second,
  output logic [7:0]       bcd_year,
  output logic [4:0]       bcd_month,
  output logic [5:0]       bcd_day,
  output logic [5:0]       bcd_hour,
  output logic [6:0]       bcd_minute,
  output logic [6:0]       bcd_second
);

  // hour count, minute and second
  logic       hms_valid;
  logic       hms_ready;
  esbd_hms_t  hms;

  // year and hour within the year
  logic       yr_valid;
  logic       yr_ready;
  esbd_yr_t   yr;

  // binary date and time
  logic       date_valid;
  logic       date_ready;
  esbd_date_t date;

  logic       adv;
  logic [7:0] yy;
  logic [6:0] yy_mod;

  esbd_hms u_hms (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .epoch_seconds (epoch_seconds),
    .out_valid     (hms_valid),
    .out_ready     (hms_ready),
    .out_data      (hms)
  );

  esbd_year u_year (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hms_valid),
    .in_ready  (hms_ready),
    .in_data   (hms),
    .out_valid (yr_valid),
    .out_ready (yr_ready),
    .out_data  (yr)
  );

  esbd_date u_date (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (yr_valid),
    .in_ready  (yr_ready),
    .in_data   (yr),
    .out_valid (date_valid),
    .out_ready (date_ready),
    .out_data  (date)
  );

  // Output register: advance when empty or when the receiver takes the word
  assign adv        = !out_valid || out_ready;
  assign date_ready = adv;

  // Year digits: drop the century, fold the range 70..206 into 0..99
  assign yy = 8'(date.year - CENTURY_BASE);
  always_comb begin
    priority if (yy >= 8'd200) begin
      yy_mod = 7'(yy - 8'd200);
    end else if (yy >= 8'd100) begin
      yy_mod = 7'(yy - 8'd100);
    end else begin
      yy_mod = yy[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= date_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      year       <= date.year;
      month      <= date.month;
      day        <= date.day;
      hour       <= date.hour;
      minute     <= date.minute;
      second     <= date.second;
      bcd_year   <= to_bcd(yy_mod);
      bcd_month  <= 5'(to_bcd({3'b0, date.month}));
      bcd_day    <= 6'(to_bcd({2'b0, date.day}));
      bcd_hour   <= 6'(to_bcd({2'b0, date.hour}));
      bcd_minute <= 7'(to_bcd({1'b0, date.minute}));
      bcd_second <= 7'(to_bcd({1'b0, date.second}));
    end
  end

  // A delivered month lies in 1..12 and its day in 1..31, at most 29 in February
  a_month_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1) && (month <= 4'd12))
    else $error("month out of range");

  a_day_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (day >= 5'd1) && (day <= 5'd31) && !((month == 4'd2) && (day > 5'd29)))
    else $error("day out of range");

  a_time_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59))
    else $error("time of day out of range");

  // BCD and binary copies of the seconds agree
  a_bcd_second : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (7'(bcd_second[6:4]) * 7'd10 + 7'(bcd_second[3:0])) == {1'b0, second})
    else $error("bcd_second does not match second");

endmodule

`default_nettype wire
